// File: hw/rtl/omfe_pkg.sv
// Package: message type codes, field layout tables and word types of the extractor.
package omfe_pkg;

   // Type bytes that open a message
   localparam logic [7:0] TYPE_BYTE_U = 8'h55;  // 'U'
   localparam logic [7:0] TYPE_BYTE_R = 8'h52;  // 'R'
   localparam logic [7:0] TYPE_BYTE_X = 8'h58;  // 'X'
   localparam logic [7:0] TYPE_BYTE_A = 8'h41;  // 'A'
   localparam logic [7:0] TYPE_BYTE_LR = 8'h72; // 'r'
   localparam logic [7:0] TYPE_BYTE_C = 8'h43;  // 'C'
   localparam logic [7:0] TYPE_BYTE_E = 8'h45;  // 'E'
   localparam logic [7:0] TYPE_BYTE_J = 8'h4A;  // 'J'

   // Message codes as reported on the result channel
   localparam logic [2:0] CODE_U = 3'd0;
   localparam logic [2:0] CODE_R = 3'd1;
   localparam logic [2:0] CODE_X = 3'd2;
   localparam logic [2:0] CODE_A = 3'd3;
   localparam logic [2:0] CODE_LR = 3'd4;
   localparam logic [2:0] CODE_C = 3'd5;
   localparam logic [2:0] CODE_E = 3'd6;
   localparam logic [2:0] CODE_J = 3'd7;

   // Input kinds and result status codes
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;
   localparam logic STATUS_FIELD = 1'b0;
   localparam logic STATUS_BAD_TYPE = 1'b1;

   localparam logic [3:0] CHUNK_BYTES = 4'd8;
   localparam logic [3:0] MAX_FIELD_BYTES = 4'd14;

   // Field widths in bytes per message code; unused slots are zero
   localparam logic [3:0] FIELD_WIDTH [8][16] = '{
      '{4'd4, 4'd1, 4'd4, 4'd8, 4'd8, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd14, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4},
      '{4'd4, 4'd4, 4'd4, 4'd8, 4'd1, 4'd1, 4'd1, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd4, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd8, 4'd4, 4'd8, 4'd1, 4'd8, 4'd4, 4'd8, 4'd1,
        4'd1, 4'd1, 4'd14, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd8, 4'd4, 4'd4, 4'd8, 4'd4, 4'd8, 4'd1, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd8, 4'd4, 4'd4, 4'd4, 4'd1, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd8, 4'd4, 4'd4, 4'd8, 4'd1, 4'd8, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd8, 4'd4, 4'd1, 4'd14, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
   };

   // Number of fields per message code
   localparam logic [4:0] FIELD_COUNT [8] = '{
      5'd16, 5'd7, 5'd2, 5'd11, 5'd7, 5'd5, 5'd6, 5'd4
   };

   typedef enum logic {
      ST_IDLE,
      ST_BODY
   } parse_state_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] code;
   } type_lookup_type;

   typedef struct packed {
      logic        status;
      logic [2:0]  msg_code;
      logic [3:0]  field_index;
      logic        part_index;
      logic [63:0] value;
      logic [3:0]  value_bytes;
      logic        last_in_message;
   } rsp_word_type;

   // Map a type byte to its message code
   function automatic type_lookup_type lookup_type(input logic [7:0] b);
      type_lookup_type r;
      r.hit = 1'b1;
      r.code = CODE_U;
      case (b)
         TYPE_BYTE_U: r.code = CODE_U;
         TYPE_BYTE_R: r.code = CODE_R;
         TYPE_BYTE_X: r.code = CODE_X;
         TYPE_BYTE_A: r.code = CODE_A;
         TYPE_BYTE_LR: r.code = CODE_LR;
         TYPE_BYTE_C: r.code = CODE_C;
         TYPE_BYTE_E: r.code = CODE_E;
         TYPE_BYTE_J: r.code = CODE_J;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/omfe_ifs.sv
// Interfaces: byte request channel and field result channel.
interface omfe_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface omfe_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [2:0]  msg_code;
   logic [3:0]  field_index;
   logic        part_index;
   logic [63:0] value;
   logic [3:0]  value_bytes;
   logic        last_in_message;

   modport source (output valid, output status, output msg_code, output field_index,
                   output part_index, output value, output value_bytes,
                   output last_in_message, input ready);
   modport sink (input valid, input status, input msg_code, input field_index,
                 input part_index, input value, input value_bytes,
                 input last_in_message, output ready);
endinterface

// File: hw/rtl/omfe_parser.sv
// Parser: message state, field accumulator and result word formation per byte.
module omfe_parser
   import omfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic         kind,
   input  logic [7:0]   data_byte,
   output logic         emit,
   output rsp_word_type word
);

   parse_state_type state_ff, state_in;
   logic [2:0]  code_ff, code_in;
   logic [3:0]  field_ff, field_in;
   logic [3:0]  count_ff, count_in;
   logic [63:0] acc_ff, acc_in;

   type_lookup_type lookup;
   logic [3:0]  width;
   logic [3:0]  count_inc;
   logic [63:0] acc_new;
   logic        field_done;
   logic        chunk_done;
   logic        last_field;
   logic        part;

   // Decode current byte against the field layout
   always_comb begin
      lookup = lookup_type(data_byte);
      width = FIELD_WIDTH[code_ff][field_ff];
      count_inc = count_ff + 4'd1;
      acc_new = acc_ff | ({56'd0, data_byte} << {count_ff[2:0], 3'b000});
      field_done = (count_inc >= width);
      chunk_done = (count_inc == CHUNK_BYTES);
      last_field = (({1'b0, field_ff} + 5'd1) >= FIELD_COUNT[code_ff]);
      part = count_ff[3];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         if (kind == KIND_FLUSH) begin
            state_in = ST_IDLE;
         end else begin
            case (state_ff)
               ST_IDLE: begin
                  if (lookup.hit) state_in = ST_BODY;
               end
               ST_BODY: begin
                  if (field_done && last_field) state_in = ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
      end
   end

   // Datapath updates and result word
   always_comb begin
      code_in = code_ff;
      field_in = field_ff;
      count_in = count_ff;
      acc_in = acc_ff;
      emit = 1'b0;
      word.status = STATUS_FIELD;
      word.msg_code = code_ff;
      word.field_index = field_ff;
      word.part_index = 1'b0;
      word.value = acc_new;
      word.value_bytes = CHUNK_BYTES;
      word.last_in_message = 1'b0;
      if (accept && kind == KIND_DATA) begin
         case (state_ff)
            ST_IDLE: begin
               if (lookup.hit) begin
                  code_in = lookup.code;
                  field_in = 4'd0;
                  count_in = 4'd0;
                  acc_in = 64'd0;
               end else begin
                  emit = 1'b1;
                  word.status = STATUS_BAD_TYPE;
                  word.msg_code = CODE_U;
                  word.field_index = 4'd0;
                  word.value = {56'd0, data_byte};
                  word.value_bytes = 4'd1;
               end
            end
            ST_BODY: begin
               if (field_done) begin
                  emit = 1'b1;
                  word.part_index = part;
                  word.value_bytes = part ? (count_inc - CHUNK_BYTES) : count_inc;
                  word.last_in_message = last_field;
                  field_in = field_ff + 4'd1;
                  count_in = 4'd0;
                  acc_in = 64'd0;
               end else if (chunk_done) begin
                  emit = 1'b1;
                  count_in = count_inc;
                  acc_in = 64'd0;
               end else begin
                  count_in = count_inc;
                  acc_in = acc_new;
               end
            end
            default: ;
         endcase
      end
   end

   // Hold control state; accumulator carries payload only
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         code_ff <= CODE_U;
         field_ff <= 4'd0;
         count_ff <= 4'd0;
      end else begin
         state_ff <= state_in;
         code_ff <= code_in;
         field_ff <= field_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < MAX_FIELD_BYTES)
      else $error("field byte count out of range");

   a_field_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BODY |-> {1'b0, field_ff} < FIELD_COUNT[code_ff])
      else $error("field number beyond message layout");

   a_bad_type_when_idle: assert property (@(posedge clock) disable iff (reset)
      emit && word.status == STATUS_BAD_TYPE |-> state_ff == ST_IDLE)
      else $error("bad type word raised inside a message");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      emit && word.last_in_message |=> state_ff == ST_IDLE)
      else $error("message still open after its last field");

endmodule

// File: hw/rtl/omfe_rsp_reg.sv
// Result register: holds one result word until the sink takes it.
module omfe_rsp_reg
   import omfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_word_type word_in,
   input  logic         sink_ready,
   output logic         can_take,
   output logic         valid,
   output rsp_word_type word_out
);

   logic         valid_ff, valid_in;
   rsp_word_type word_ff, word_in_sel;

   // Room for a new word when empty or the held word leaves this cycle
   assign can_take = !valid_ff || sink_ready;

   always_comb begin
      valid_in = valid_ff;
      word_in_sel = word_ff;
      if (can_take) begin
         valid_in = load;
         word_in_sel = word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in_sel;
   end

   assign valid = valid_ff;
   assign word_out = word_ff;

endmodule

// File: hw/rtl/order_message_field_extractor_top.sv
// Top level: order message field extractor.
// A result word is held in the output register from the cycle after its byte is taken.
// Throughput: one byte per cycle; req ready drops only while a held result is not taken.
// Each byte yields zero or one result word; type bytes and mid-chunk bytes yield none.
// Reset (synchronous, active high) closes any open message and empties the output register.
module order_message_field_extractor_top
   import omfe_pkg::*;
(
   input  logic clock,
   input  logic reset,
   omfe_req_if.sink   req_chan,
   omfe_rsp_if.source rsp_chan
);

   logic         accept;
   logic         can_take;
   logic         emit;
   logic         rsp_valid;
   rsp_word_type parse_word;
   rsp_word_type out_word;

   // Take a byte whenever the result register has room
   assign req_chan.ready = can_take;
   assign accept = req_chan.valid && can_take;

   omfe_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_chan.kind),
      .data_byte (req_chan.data_byte),
      .emit      (emit),
      .word      (parse_word)
   );

   omfe_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (emit),
      .word_in    (parse_word),
      .sink_ready (rsp_chan.ready),
      .can_take   (can_take),
      .valid      (rsp_valid),
      .word_out   (out_word)
   );

   // Drive result channel
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.status = out_word.status;
   assign rsp_chan.msg_code = out_word.msg_code;
   assign rsp_chan.field_index = out_word.field_index;
   assign rsp_chan.part_index = out_word.part_index;
   assign rsp_chan.value = out_word.value;
   assign rsp_chan.value_bytes = out_word.value_bytes;
   assign rsp_chan.last_in_message = out_word.last_in_message;

endmodule

// File: tb/tb.sv
// Testbench for the order message field extractor: byte stream in, field words checked.
`timescale 1ns / 100ps

module tb;
   import omfe_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_BYTES = 800;
   localparam int TAIL_BYTES = 60;    // no idling once this few bytes remain
   localparam int HOLD_AFTER = 80;    // result words taken before the long receiver hold
   localparam int HOLD_CYCLES = 120;
   localparam int MAX_PRINTED = 40;

   // Message layout per message code, kept independent of the design's tables
   localparam logic [7:0] TYPE_CHAR [8] = '{TYPE_BYTE_U, TYPE_BYTE_R, TYPE_BYTE_X,
      TYPE_BYTE_A, TYPE_BYTE_LR, TYPE_BYTE_C, TYPE_BYTE_E, TYPE_BYTE_J};
   localparam int MSG_LENGTH [8] = '{65, 24, 9, 59, 38, 22, 34, 28};
   localparam int NUM_FIELDS [8] = '{16, 7, 2, 11, 7, 5, 6, 4};
   localparam int FIELD_BYTES [8][16] = '{
      '{4, 1, 4, 8, 8, 1, 1, 1, 1, 1, 14, 4, 4, 4, 4, 4},
      '{4, 4, 4, 8, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{4, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{8, 4, 8, 1, 8, 4, 8, 1, 1, 1, 14, 0, 0, 0, 0, 0},
      '{8, 4, 4, 8, 4, 8, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{8, 4, 4, 4, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{8, 4, 4, 8, 1, 8, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{8, 4, 1, 14, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
   };

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } stream_byte_type;

   logic clock;
   logic reset;

   omfe_req_if req_chan ();
   omfe_rsp_if rsp_chan ();

   order_message_field_extractor_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   stream_byte_type byte_stream [$];
   rsp_word_type predicted_fields [$];
   int error_count = 0;
   int cycle_count = 0;
   int words_taken = 0;

   // Parser state of the predictor
   logic        open_msg = 1'b0;
   logic [2:0]  open_code = CODE_U;
   int          field_num = 0;
   int          field_fill = 0;
   logic [63:0] field_acc = '0;

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED)
         $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic string word_text(input rsp_word_type w);
      return $sformatf("st=%0d code=%0d fld=%0d part=%0d val=%h nb=%0d last=%0d",
                       w.status, w.msg_code, w.field_index, w.part_index, w.value,
                       w.value_bytes, w.last_in_message);
   endfunction

   task automatic close_message();
      open_msg = 1'b0;
      open_code = CODE_U;
      field_num = 0;
      field_fill = 0;
      field_acc = '0;
   endtask

   // Advance the parser by one accepted byte and queue the field, chunk or bad-type word it yields
   task automatic extract_field(input stream_byte_type item);
      rsp_word_type w;
      int width;
      int part;
      bit known;
      w = '0;
      known = 1'b0;
      if (item.kind == KIND_FLUSH) begin
         close_message();
      end else if (!open_msg) begin
         for (int c = 0; c < 8; c++) begin
            if (!known && TYPE_CHAR[c] == item.data_byte) begin
               close_message();
               open_msg = 1'b1;
               open_code = 3'(c);
               known = 1'b1;
            end
         end
         if (!known) begin
            w.status = STATUS_BAD_TYPE;
            w.msg_code = CODE_U;
            w.value = 64'(item.data_byte);
            w.value_bytes = 4'd1;
            predicted_fields.push_back(w);
         end
      end else begin
         width = FIELD_BYTES[open_code][field_num];
         field_acc = field_acc | (64'(item.data_byte) << (8 * (field_fill % 8)));
         field_fill++;
         w.status = STATUS_FIELD;
         w.msg_code = open_code;
         w.field_index = 4'(field_num);
         if (field_fill >= width) begin
            part = (field_fill - 1) / 8;
            w.part_index = 1'(part);
            w.value = field_acc;
            w.value_bytes = 4'(field_fill - part * 8);
            w.last_in_message = (field_num + 1 >= NUM_FIELDS[open_code]);
            predicted_fields.push_back(w);
            if (w.last_in_message) begin
               close_message();
            end else begin
               field_num++;
               field_fill = 0;
               field_acc = '0;
            end
         end else if (field_fill == 8) begin
            // first chunk of a long string field
            w.value = field_acc;
            w.value_bytes = 4'd8;
            predicted_fields.push_back(w);
            field_acc = '0;
         end
      end
   endtask

   // Driver: offer queued bytes with random gaps, hold a byte until it is taken
   int send_gap = 0;
   always @(posedge clock) begin
      stream_byte_type next_item;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.kind <= KIND_DATA;
         req_chan.data_byte <= 8'h00;
      end else begin
         if (req_chan.valid && req_chan.ready)
            extract_field('{kind: req_chan.kind, data_byte: req_chan.data_byte});
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (byte_stream.size() > TAIL_BYTES && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 3);
               req_chan.valid <= 1'b0;
            end else if (byte_stream.size() > 0) begin
               next_item = byte_stream.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.kind <= next_item.kind;
               req_chan.data_byte <= next_item.data_byte;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each taken word, stall at random, and hold off once for a long stretch
   int stall_gap = 0;
   int long_hold = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.status, rsp_chan.msg_code, rsp_chan.field_index,
                   rsp_chan.part_index, rsp_chan.value, rsp_chan.value_bytes,
                   rsp_chan.last_in_message};
            if (predicted_fields.size() == 0) begin
               report_mismatch({"unexpected word ", word_text(got)});
            end else begin
               want = predicted_fields.pop_front();
               if (got !== want)
                  report_mismatch({"got ", word_text(got), " want ", word_text(want)});
            end
            words_taken++;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_chan.ready <= 1'b0;
         end else if (!hold_done && words_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            long_hold = HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else if (stall_gap > 0) begin
            stall_gap--;
            rsp_chan.ready <= 1'b0;
         end else if (byte_stream.size() > TAIL_BYTES && $urandom_range(0, 5) == 0) begin
            stall_gap = $urandom_range(0, 3);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      byte_stream.push_back('{kind: KIND_DATA, data_byte: b});
   endtask

   task automatic push_flush();
      byte_stream.push_back('{kind: KIND_FLUSH, data_byte: 8'($urandom_range(0, 255))});
   endtask

   function automatic logic [7:0] body_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Type byte of the given code and then body bytes up to the given total
   task automatic push_message(input int code, input int total);
      push_byte(TYPE_CHAR[code]);
      for (int i = 1; i < total; i++)
         push_byte(body_byte());
   endtask

   initial begin
      int code;
      clock = 1'b0;
      reset = 1'b1;

      // Directed: idle flush, unknown type bytes, a short message with extreme bytes,
      // a partial message dropped by flush, a lone type byte dropped by flush
      push_flush();
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(TYPE_CHAR[CODE_X]);
      for (int i = 0; i < 4; i++) push_byte(8'hFF);
      for (int i = 0; i < 4; i++) push_byte(8'h00);
      push_message(CODE_R, 4);
      push_flush();
      push_byte(TYPE_CHAR[CODE_C]);
      push_flush();
      push_flush();

      // Random: mostly whole messages, some noise and cut-off messages
      while (byte_stream.size() < RANDOM_BYTES + 20) begin
         code = $urandom_range(0, 7);
         case ($urandom_range(0, 9))
            0: push_byte(8'($urandom_range(0, 255)));
            1: begin
               push_message(code, $urandom_range(1, MSG_LENGTH[code] - 1));
               push_flush();
            end
            2: begin
               push_message(code, MSG_LENGTH[code]);
               push_flush();
            end
            default: push_message(code, MSG_LENGTH[code]);
         endcase
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Drain: all bytes taken, all words seen, then a quiet wait
      while (byte_stream.size() > 0 || req_chan.valid) @(posedge clock);
      while (predicted_fields.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/omfe_pkg.sv
hw/rtl/omfe_ifs.sv
hw/rtl/omfe_parser.sv
hw/rtl/omfe_rsp_reg.sv
hw/rtl/order_message_field_extractor_top.sv
tb/tb.sv
